/* hw/rtl/lpmr_pkg.sv */
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring: ring size,
// input opcodes, command encoding between front and back, and payload structs.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  // ring geometry
  localparam int RING_BYTES = 64;
  localparam int ADDR_W     = $clog2(RING_BYTES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int MAX_CHARS  = 64;

  // result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = RQ_AW + 1;

  // input opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_REJ   = 2'd3;

  typedef logic [ADDR_W-1:0] idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_CLOSE,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic       sink_busy;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DATA
  } bk_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       sink_busy;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
    logic [6:0] free_space;
  } result_t;

endpackage

/* hw/rtl/lpmr_front.sv */
// ----------------------------------------------------------------------------
// lpmr_front
// Accepts input requests, decodes the opcode into a command and holds the
// commands in a two-entry queue for the back end. Unused opcodes are dropped.
// ----------------------------------------------------------------------------
module lpmr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lpmr_pkg::item_t  item,
  output logic             cmd_valid,
  output lpmr_pkg::cmd_t   cmd,
  input  logic             cmd_take
);

  lpmr_pkg::cmd_t entries [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           accept;
  logic           known;
  lpmr_pkg::cmd_t decoded;

  // opcode decode
  always_comb begin
    decoded.data_byte = item.data_byte;
    decoded.sink_busy = item.sink_busy;
    case (item.opcode)
      lpmr_pkg::OP_PUSH: begin
        decoded.kind = lpmr_pkg::CMD_PUSH;
        known        = 1'b1;
      end
      lpmr_pkg::OP_CLOSE: begin
        decoded.kind = lpmr_pkg::CMD_CLOSE;
        known        = 1'b1;
      end
      lpmr_pkg::OP_POP: begin
        decoded.kind = lpmr_pkg::CMD_POP;
        known        = 1'b1;
      end
      default: begin
        decoded.kind = lpmr_pkg::CMD_PUSH;
        known        = 1'b0;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full && known;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rptr];

  // command queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wptr] <= decoded;
    end
  end

  // command queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (cmd_take) begin
        rptr <= ~rptr;
      end
      case ({accept, cmd_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/lpmr_result_queue.sv */
// ----------------------------------------------------------------------------
// lpmr_result_queue
// Four-entry result queue between the back end and the result port; the
// back end reserves a slot for every ring read it issues.
// ----------------------------------------------------------------------------
module lpmr_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  lpmr_pkg::result_t             wr_data,
  output logic [lpmr_pkg::RQ_CW-1:0]    count,
  output logic                          empty,
  input  logic                          pop,
  output lpmr_pkg::result_t             result
);

  lpmr_pkg::result_t                entries [lpmr_pkg::RQ_DEPTH];
  logic [lpmr_pkg::RQ_AW-1:0]       wptr;
  logic [lpmr_pkg::RQ_AW-1:0]       rptr;
  logic                             take;

  assign empty  = (count == '0);
  assign take   = pop && !empty;
  assign result = entries[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  // back end must never write into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    wr |-> (count != lpmr_pkg::RQ_CW'(lpmr_pkg::RQ_DEPTH)))
    else $error("result queue overrun");
`endif

endmodule

/* hw/rtl/lpmr_back.sv */
// ----------------------------------------------------------------------------
// lpmr_back
// Executes commands against the single-port ring memory: stages characters,
// commits messages with their length header and streams the oldest message
// out one character per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module lpmr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  lpmr_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  logic [lpmr_pkg::RQ_CW-1:0]    res_count,
  output logic                          res_wr,
  output lpmr_pkg::result_t             res_data
);

  // ring memory
  logic [7:0]          mem [lpmr_pkg::RING_BYTES];
  logic                mem_en;
  logic                mem_we;
  lpmr_pkg::idx_t      mem_addr;
  logic [7:0]          mem_wdata;
  logic [7:0]          rd_data;

  // registers
  lpmr_pkg::bk_state_t state;
  lpmr_pkg::bk_state_t state_next;
  lpmr_pkg::idx_t      head;
  lpmr_pkg::idx_t      tail;
  lpmr_pkg::cnt_t      staged_count;
  logic                staged_ovf;
  lpmr_pkg::idx_t      rd_ptr;
  lpmr_pkg::idx_t      rd_left;
  logic                rd_pending;
  logic                pend_last;

  // datapath values
  lpmr_pkg::idx_t      used;
  lpmr_pkg::cnt_t      free_now;
  logic                ring_empty;
  logic                room;
  logic                push_fits;
  logic                close_ok;
  lpmr_pkg::idx_t      tail_commit;
  lpmr_pkg::cnt_t      free_close;
  logic [7:0]          hdr_n;
  lpmr_pkg::idx_t      pop_n;
  lpmr_pkg::idx_t      head_adv;
  lpmr_pkg::cnt_t      free_adv;

  // control
  logic                stage_inc;
  logic                set_ovf;
  logic                commit;
  logic                clear_stage;
  logic                hdr_done;
  logic                issue_rd;

  // occupancy and fit checks
  always_comb begin
    used        = tail - head;
    free_now    = lpmr_pkg::CNT_W'(lpmr_pkg::RING_BYTES - 1) - {1'b0, used};
    ring_empty  = (head == tail);
    room        = (res_count + lpmr_pkg::RQ_CW'(rd_pending))
                  < lpmr_pkg::RQ_CW'(lpmr_pkg::RQ_DEPTH);
    push_fits   = ({1'b0, staged_count} + (lpmr_pkg::CNT_W + 1)'(2)) <= {1'b0, free_now}
                  && staged_count < lpmr_pkg::CNT_W'(lpmr_pkg::MAX_CHARS);
    close_ok    = !staged_ovf
                  && ({1'b0, staged_count} + (lpmr_pkg::CNT_W + 1)'(1)) <= {1'b0, free_now};
    tail_commit = tail + staged_count[lpmr_pkg::ADDR_W-1:0] + 1'b1;
    free_close  = close_ok
                  ? lpmr_pkg::CNT_W'(lpmr_pkg::RING_BYTES - 1) - {1'b0, tail_commit - head}
                  : free_now;
  end

  // header decode: length minus one, cut to the committed bytes
  always_comb begin
    hdr_n = (rd_data == 8'd0) ? 8'd0 : rd_data - 8'd1;
    if ({1'b0, hdr_n} + 9'd1 > 9'({1'b0, used})) begin
      pop_n = used - 1'b1;
    end else begin
      pop_n = hdr_n[lpmr_pkg::ADDR_W-1:0];
    end
    head_adv = head + pop_n + 1'b1;
    free_adv = lpmr_pkg::CNT_W'(lpmr_pkg::RING_BYTES - 1) - {1'b0, tail - head_adv};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lpmr_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.kind == lpmr_pkg::CMD_POP && !cmd.sink_busy && !ring_empty) begin
          state_next = lpmr_pkg::BK_HDR;
        end
      end
      lpmr_pkg::BK_HDR: begin
        if (room) begin
          state_next = (pop_n == '0) ? lpmr_pkg::BK_IDLE : lpmr_pkg::BK_DATA;
        end
      end
      lpmr_pkg::BK_DATA: begin
        if (rd_left == '0 && !rd_pending) begin
          state_next = lpmr_pkg::BK_IDLE;
        end
      end
      default: state_next = lpmr_pkg::BK_IDLE;
    endcase
  end

  // outputs and control
  always_comb begin
    cmd_take    = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = head;
    mem_wdata   = cmd.data_byte;
    res_wr      = 1'b0;
    res_data    = '0;
    stage_inc   = 1'b0;
    set_ovf     = 1'b0;
    commit      = 1'b0;
    clear_stage = 1'b0;
    hdr_done    = 1'b0;
    issue_rd    = 1'b0;
    res_data.last       = 1'b1;
    res_data.status     = lpmr_pkg::ST_OK;
    res_data.free_space = 7'(free_now);
    case (state)
      lpmr_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            lpmr_pkg::CMD_PUSH: begin
              cmd_take = 1'b1;
              if (!staged_ovf) begin
                if (push_fits) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = tail + 1'b1 + staged_count[lpmr_pkg::ADDR_W-1:0];
                  stage_inc = 1'b1;
                end else begin
                  set_ovf = 1'b1;
                end
              end
            end
            lpmr_pkg::CMD_CLOSE: begin
              if (room) begin
                cmd_take    = 1'b1;
                clear_stage = 1'b1;
                res_wr      = 1'b1;
                res_data.free_space = 7'(free_close);
                if (close_ok) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = tail;
                  mem_wdata = 8'(staged_count + 1'b1);
                  commit    = 1'b1;
                end else begin
                  res_data.status = lpmr_pkg::ST_REJ;
                end
              end
            end
            lpmr_pkg::CMD_POP: begin
              if (cmd.sink_busy || ring_empty) begin
                if (room) begin
                  cmd_take = 1'b1;
                  res_wr   = 1'b1;
                  res_data.status = cmd.sink_busy ? lpmr_pkg::ST_BUSY : lpmr_pkg::ST_EMPTY;
                end
              end else begin
                // fetch the header of the oldest message
                cmd_take = 1'b1;
                mem_en   = 1'b1;
                mem_addr = head;
              end
            end
            default: cmd_take = 1'b0;
          endcase
        end
      end
      lpmr_pkg::BK_HDR: begin
        if (room) begin
          hdr_done = 1'b1;
          if (pop_n == '0) begin
            res_wr = 1'b1;
            res_data.free_space = 7'(free_adv);
          end
        end
      end
      lpmr_pkg::BK_DATA: begin
        if (rd_left != '0 && room) begin
          issue_rd = 1'b1;
          mem_en   = 1'b1;
          mem_addr = rd_ptr;
        end
        if (rd_pending) begin
          res_wr              = 1'b1;
          res_data.out_byte   = rd_data;
          res_data.byte_valid = 1'b1;
          res_data.last       = pend_last;
        end
      end
      default: cmd_take = 1'b0;
    endcase
  end

  // single-port ring memory
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rd_data <= mem[mem_addr];
      end
    end
  end

  // read stream registers
  always_ff @(posedge clk) begin
    if (hdr_done) begin
      rd_ptr <= head + 1'b1;
    end else if (issue_rd) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (issue_rd) begin
      pend_last <= (rd_left == lpmr_pkg::ADDR_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lpmr_pkg::BK_IDLE;
      head         <= '0;
      tail         <= '0;
      staged_count <= '0;
      staged_ovf   <= 1'b0;
      rd_left      <= '0;
      rd_pending   <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= issue_rd;
      if (clear_stage) begin
        staged_count <= '0;
        staged_ovf   <= 1'b0;
      end else begin
        if (stage_inc) begin
          staged_count <= staged_count + 1'b1;
        end
        if (set_ovf) begin
          staged_ovf <= 1'b1;
        end
      end
      if (commit) begin
        tail <= tail_commit;
      end
      if (hdr_done) begin
        head    <= head_adv;
        rd_left <= pop_n;
      end else if (issue_rd) begin
        rd_left <= rd_left - 1'b1;
      end
    end
  end

`ifndef SYNTH
  // the marked character is the final read of the message
  a_last_final: assert property (@(posedge clk) disable iff (rst)
    (rd_pending && pend_last) |-> (rd_left == '0))
    else $error("last flag set with reads outstanding");

  // staged characters plus header always leave the spare slot
  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    staged_count <= lpmr_pkg::CNT_W'(lpmr_pkg::RING_BYTES - 2))
    else $error("staged count beyond ring capacity");

  // a drained message stream returns to idle
  a_data_done: assert property (@(posedge clk) disable iff (rst)
    (state == lpmr_pkg::BK_DATA && rd_left == '0 && !rd_pending)
    |=> (state == lpmr_pkg::BK_IDLE))
    else $error("message stream did not finish");
`endif

endmodule

/* hw/rtl/length_prefixed_message_ring.sv */
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Byte ring of length-prefixed messages with queue-style request and result
// channels.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full with an item (opcode, data_byte,
//   sink_busy); results leave through empty/pop, the oldest on result.
//   A push-character request gives no result. A close, a refused pop and
//   an empty pop each give one result, written into the result queue as
//   the back end takes the request. A pop of a message of n characters
//   holds the back end for a header read, a header decode, n ring reads
//   at one per cycle while the result queue has room, and the drain of the
//   last read; the single-port ring memory sets the rate of one byte
//   access per cycle.
//   A two-entry command queue lets requests be taken while a message streams
//   out; full rises only when it fills.
//   When the receiver stalls, the four-entry result queue fills and the back
//   end pauses its ring reads; nothing is lost.
//   Reset (rst, synchronous) empties the ring, drops any staged message and
//   clears both queues; the ring contents need no clearing.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lpmr_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output lpmr_pkg::result_t   result
);

  logic                         cmd_valid;
  lpmr_pkg::cmd_t               cmd;
  logic                         cmd_take;
  logic [lpmr_pkg::RQ_CW-1:0]   res_count;
  logic                         res_wr;
  lpmr_pkg::result_t            res_data;

  // request decode and command queue
  lpmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // ring execution
  lpmr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_count (res_count),
    .res_wr    (res_wr),
    .res_data  (res_data)
  );

  // result queue
  lpmr_result_queue u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (res_data),
    .count   (res_count),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed message ring. Requests go in
// through push/full, results come out through empty/pop, and both sides idle
// at random outside a steady stretch. A behavioral copy of the ring predicts
// every result. Each result is checked field by field against the oldest
// prediction. A short directed table runs first, then random message traffic.
// ----------------------------------------------------------------------------
module testbench;

  // opcode the block ignores
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 200;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  lpmr_pkg::item_t   req_item;
  logic              empty;
  logic              pop;
  lpmr_pkg::result_t res_word;

  length_prefixed_message_ring DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (req_item),
    .empty  (empty),
    .pop    (pop),
    .result (res_word)
  );

  // directed row: request fields, and a typed answer where one is obvious
  typedef struct {
    logic [1:0]        opcode;
    logic [7:0]        data_byte;
    logic              sink_busy;
    bit                typed;
    lpmr_pkg::result_t want;
  } plan_row_t;

  plan_row_t plan [16] = '{
    // pop right after reset finds nothing
    '{lpmr_pkg::OP_POP,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_EMPTY, 7'd63}},
    // busy sink wins over empty ring
    '{lpmr_pkg::OP_POP,   8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_BUSY,  7'd63}},
    // empty message costs one header byte
    '{lpmr_pkg::OP_CLOSE, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_OK,    7'd62}},
    '{lpmr_pkg::OP_POP,   8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_OK,    7'd63}},
    // unused opcode does nothing
    '{OP_SPARE,           8'hFF, 1'b1, 1'b0, '0},
    // character extremes
    '{lpmr_pkg::OP_PUSH,  8'h00, 1'b0, 1'b0, '0},
    '{lpmr_pkg::OP_PUSH,  8'hFF, 1'b1, 1'b0, '0},
    '{lpmr_pkg::OP_PUSH,  8'hA5, 1'b0, 1'b0, '0},
    '{lpmr_pkg::OP_PUSH,  8'h5A, 1'b0, 1'b0, '0},
    '{lpmr_pkg::OP_CLOSE, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_OK,    7'd58}},
    '{lpmr_pkg::OP_POP,   8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_BUSY,  7'd58}},
    '{lpmr_pkg::OP_POP,   8'hC3, 1'b0, 1'b0, '0},
    '{lpmr_pkg::OP_POP,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_EMPTY, 7'd63}},
    // single character then a back-to-back close and pop
    '{lpmr_pkg::OP_PUSH,  8'h81, 1'b0, 1'b0, '0},
    '{lpmr_pkg::OP_CLOSE, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, lpmr_pkg::ST_OK,    7'd61}},
    '{lpmr_pkg::OP_POP,   8'h7E, 1'b0, 1'b0, '0}
  };

  // shadow ring state
  logic [7:0]     ring_copy [lpmr_pkg::RING_BYTES];
  lpmr_pkg::idx_t rd_pos = '0;
  lpmr_pkg::idx_t wr_pos = '0;
  int             staged = 0;
  bit             staged_bad = 1'b0;

  lpmr_pkg::result_t pending_results [$];
  int                mismatches = 0;
  bit                steady = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int ring_room();
    return lpmr_pkg::RING_BYTES - 1 - int'(lpmr_pkg::idx_t'(wr_pos - rd_pos));
  endfunction

  // predict the results of one accepted request and update the shadow ring
  function automatic void predict_request(input lpmr_pkg::item_t it);
    int                used;
    int                room;
    int                n;
    int                hdr;
    lpmr_pkg::idx_t    start;
    lpmr_pkg::result_t r;
    used = int'(lpmr_pkg::idx_t'(wr_pos - rd_pos));
    room = lpmr_pkg::RING_BYTES - 1 - used;
    r = '0;
    r.last = 1'b1;
    case (it.opcode)
      lpmr_pkg::OP_PUSH: begin
        if (!staged_bad) begin
          if (staged + 2 <= room && staged < lpmr_pkg::MAX_CHARS) begin
            ring_copy[lpmr_pkg::idx_t'(wr_pos + 1 + staged)] = it.data_byte;
            staged++;
          end else begin
            staged_bad = 1'b1;
          end
        end
      end
      lpmr_pkg::OP_CLOSE: begin
        r.status = lpmr_pkg::ST_OK;
        if (staged_bad || staged + 1 > room) begin
          r.status = lpmr_pkg::ST_REJ;
        end else begin
          ring_copy[wr_pos] = 8'(staged + 1);
          wr_pos = lpmr_pkg::idx_t'(wr_pos + staged + 1);
        end
        staged = 0;
        staged_bad = 1'b0;
        r.free_space = 7'(ring_room());
        pending_results.push_back(r);
      end
      lpmr_pkg::OP_POP: begin
        if (it.sink_busy) begin
          r.status = lpmr_pkg::ST_BUSY;
          r.free_space = 7'(room);
          pending_results.push_back(r);
        end else if (rd_pos == wr_pos) begin
          r.status = lpmr_pkg::ST_EMPTY;
          r.free_space = 7'(room);
          pending_results.push_back(r);
        end else begin
          hdr = int'(ring_copy[rd_pos]);
          n = (hdr == 0) ? 0 : hdr - 1;
          // header guard and length cap
          if (n + 1 > used) n = used - 1;
          if (n > lpmr_pkg::MAX_CHARS) n = lpmr_pkg::MAX_CHARS;
          start = rd_pos;
          rd_pos = lpmr_pkg::idx_t'(rd_pos + n + 1);
          r.status = lpmr_pkg::ST_OK;
          r.free_space = 7'(ring_room());
          if (n == 0) begin
            pending_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.out_byte = ring_copy[lpmr_pkg::idx_t'(start + 1 + i)];
              r.byte_valid = 1'b1;
              r.last = (i + 1 == n);
              pending_results.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // drive one request, wait for acceptance, then predict it
  task automatic send_request(input lpmr_pkg::item_t it, input bit typed,
                              input lpmr_pkg::result_t want);
    while (!steady && $urandom_range(0, 99) < 24) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req_item <= it;
    do @(posedge clk); while (full);
    predict_request(it);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    @(negedge clk);
  endtask

  // receiver idling
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !rst && (steady || $urandom_range(0, 99) >= 24);
    end
  end

  // result checking
  always @(posedge clk) begin
    lpmr_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res_word));
      end else begin
        want = pending_results.pop_front();
        if (res_word.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", res_word.out_byte, want.out_byte));
        if (res_word.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b",
                                    res_word.byte_valid, want.byte_valid));
        if (res_word.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", res_word.last, want.last));
        if (res_word.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res_word.status, want.status));
        if (res_word.free_space !== want.free_space)
          report_mismatch($sformatf("free_space %0d, want %0d",
                                    res_word.free_space, want.free_space));
      end
    end
  end

  // stimulus
  initial begin
    lpmr_pkg::item_t it;
    int              random_sent;
    int              pick;
    int              len;
    bit              pressure_done;
    rst = 1'b1;
    push = 1'b0;
    req_item = '0;
    random_sent = 0;
    pressure_done = 1'b0;
    for (int i = 0; i < lpmr_pkg::RING_BYTES; i++) ring_copy[i] = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (plan[i]) begin
      it.opcode = plan[i].opcode;
      it.data_byte = plan[i].data_byte;
      it.sink_busy = plan[i].sink_busy;
      send_request(it, plan[i].typed, plan[i].want);
    end

    // random message traffic
    while (random_sent < RANDOM_ITEMS) begin
      // hold off once until the ring has drained its results
      if (!pressure_done && random_sent >= RANDOM_ITEMS / 2) begin
        while (pending_results.size() != 0) begin
          push <= 1'b0;
          @(negedge clk);
        end
        pressure_done = 1'b1;
      end
      steady = (random_sent >= 120 && random_sent < 160);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // well-formed message: characters then close
        len = $urandom_range(0, 99);
        if (len < 70) len = $urandom_range(0, 6);
        else if (len < 85) len = $urandom_range(7, 40);
        else len = $urandom_range(50, 64);
        for (int k = 0; k < len; k++) begin
          it.opcode = lpmr_pkg::OP_PUSH;
          it.data_byte = 8'($urandom_range(0, 255));
          it.sink_busy = 1'($urandom_range(0, 1));
          send_request(it, 1'b0, '0);
          random_sent++;
        end
        it.opcode = lpmr_pkg::OP_CLOSE;
        it.data_byte = 8'($urandom_range(0, 255));
        it.sink_busy = 1'($urandom_range(0, 1));
        send_request(it, 1'b0, '0);
        random_sent++;
      end else if (pick < 82) begin
        it.opcode = lpmr_pkg::OP_POP;
        it.data_byte = 8'($urandom_range(0, 255));
        it.sink_busy = ($urandom_range(0, 9) == 0);
        send_request(it, 1'b0, '0);
        random_sent++;
      end else if (pick < 88) begin
        it.opcode = OP_SPARE;
        it.data_byte = 8'($urandom_range(0, 255));
        it.sink_busy = 1'($urandom_range(0, 1));
        send_request(it, 1'b0, '0);
      end else begin
        // noise: any request in any order
        it.opcode = 2'($urandom_range(0, 2));
        it.data_byte = 8'($urandom_range(0, 255));
        it.sink_busy = 1'($urandom_range(0, 1));
        send_request(it, 1'b0, '0);
        random_sent++;
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    // drain and let any stray result show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("length_prefixed_message_ring regression: pass");
    end else begin
      $display("length_prefixed_message_ring regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("length_prefixed_message_ring regression: fail");
    $finish;
  end

endmodule
